// ----- rtl/spifrc_pkg.sv -----
// Shared types and constants for the SPI frame receiver with CRC check.
// Used by spifrc_crc and spi_frame_receiver_crc_check. No dependencies.
`timescale 1ns / 1ps

package spifrc_pkg;

   localparam int WORD_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 6;
   localparam int RSP_DATA_W = 56;

   // configuration register indexes
   localparam logic REG_HEADER  = 1'b0;
   localparam logic REG_VERSION = 1'b1;

   // request kinds
   localparam logic CMD_WORD    = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_HEADER   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_VERSION = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CRC     = 3'd4;

   localparam logic [WORD_W-1:0] HEADER_RESET  = 16'h55AA;
   localparam logic [WORD_W-1:0] VERSION_RESET = 16'h0001;
   localparam logic [WORD_W-1:0] CRC_SEED      = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY      = 16'h1021;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VER,
      ST_CRC,
      ST_LOAD,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic clear;    // back to seed
      logic start;    // fold in a new word
      logic restart;  // new word starts from the seed
   } crc_ctrl_type;

endpackage

// ----- rtl/spifrc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module spifrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/spifrc_crc.sv -----
// Running CRC-16 (poly 0x1021, MSB first); a word is folded in eight bits per
// cycle, and busy is set while its second half is folded. Depends on spifrc_pkg.
`timescale 1ns / 1ps

module spifrc_crc (
   input  logic                          clock,
   input  logic                          reset,
   input  spifrc_pkg::crc_ctrl_type      ctrl,
   input  logic [spifrc_pkg::WORD_W-1:0] word,
   output logic [spifrc_pkg::WORD_W-1:0] crc,
   output logic                          busy
);

   logic [spifrc_pkg::WORD_W-1:0] crc_ff, crc_in;
   logic                          busy_ff, busy_in;
   logic [spifrc_pkg::WORD_W-1:0] base;

   function automatic logic [spifrc_pkg::WORD_W-1:0] step8(
      input logic [spifrc_pkg::WORD_W-1:0] c_in
   );
      logic [spifrc_pkg::WORD_W-1:0] c;
      c = c_in;
      for (int b = 0; b < 8; b++) begin
         if (c[spifrc_pkg::WORD_W-1]) begin
            c = {c[spifrc_pkg::WORD_W-2:0], 1'b0} ^ spifrc_pkg::CRC_POLY;
         end else begin
            c = {c[spifrc_pkg::WORD_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   assign base = ctrl.restart ? spifrc_pkg::CRC_SEED : crc_ff;

   always_comb begin
      crc_in  = crc_ff;
      busy_in = 1'b0;
      if (ctrl.clear) begin
         crc_in = spifrc_pkg::CRC_SEED;
      end else if (ctrl.start) begin
         crc_in  = step8(base ^ word);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         crc_in = step8(crc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= spifrc_pkg::CRC_SEED;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         busy_ff <= busy_in;
      end
   end

   assign crc  = crc_ff;
   assign busy = busy_ff;

endmodule

// ----- rtl/spi_frame_receiver_crc_check.sv -----
// Top level of the SPI frame receiver: word store, header search, version,
// completeness and CRC checks. Depends on spifrc_pkg, spifrc_ram, spifrc_crc.
`timescale 1ns / 1ps

// Usage:
//   req channel: one transaction per received SPI word (req_tuser = 0) or per
//   chip-select release (req_tuser = 1). Words beyond BUFFER_WORDS are dropped.
//   A word that joins the CRC holds off the next request until the CRC unit is
//   done (it folds 8 bits per cycle); any other word does not.
//   rsp channel: after a release, either one status transaction (tlast set) or
//   FRAME_WORDS-2 command-word transactions, the final one with tlast set.
//   A status result (no header, bad version, incomplete) is offered after the
//   version check, a CRC mismatch after the CRC compare. The first command word
//   is offered after version check, CRC compare, then the command word load
//   into the output register. Each further command word needs one read of the
//   word store and one output load.
//   No request is taken while a release is being answered; a stalled rsp_tready
//   holds the current result and the whole block until it is taken.
//   Reset clears transfer state and error counters and loads the register
//   defaults (header 0x55AA, version 0x0001). The word store is not cleared;
//   only words written in the current transfer are ever read.
//   csr port: csr_wr_en writes csr_wr_data to register csr_index (0 header,
//   1 version); write only while no transfer is pending.

module spi_frame_receiver_crc_check #(
   parameter int BUFFER_WORDS = 32,
   parameter int FRAME_WORDS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // rx_word[15:0]
   input  logic        req_tuser,    // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // cmd_word[15:0], word_index[21:16],
                                     // struct_errors[37:22], crc_errors[53:38]
   output logic [2:0]  rsp_tuser,    // status
   output logic        rsp_tlast     // last
);

   localparam int AW = $clog2(BUFFER_WORDS);
   localparam int CW = $clog2(BUFFER_WORDS + 1);
   localparam int DW = ((CW > 7) ? CW : 7) + 1;
   localparam int SW = AW + 8;
   localparam int WW = spifrc_pkg::WORD_W;
   localparam int IW = spifrc_pkg::INDEX_W;
   localparam int TW = spifrc_pkg::STATUS_W;

   localparam logic [DW-1:0] BUF_LEN   = DW'(BUFFER_WORDS);
   localparam logic [DW-1:0] FRAME_LEN = DW'(FRAME_WORDS);
   localparam logic [DW-1:0] CRC_SPAN  = DW'(FRAME_WORDS - 1);
   localparam logic [IW-1:0] LAST_IDX  = IW'(FRAME_WORDS - 3);
   localparam logic [6:0]    OFF_VER   = 7'd1;
   localparam logic [6:0]    OFF_CRC   = 7'(FRAME_WORDS - 1);
   localparam logic [6:0]    OFF_CMD   = 7'd2;

   spifrc_pkg::state_type state_ff, state_in;

   logic [WW-1:0] hdr_ff, hdr_in;
   logic [WW-1:0] ver_ff, ver_in;
   logic [CW-1:0] count_ff, count_in;
   logic          seen_ff, seen_in;
   logic [AW-1:0] hpos_ff, hpos_in;
   logic [WW-1:0] serr_ff, serr_in;
   logic [WW-1:0] cerr_ff, cerr_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [TW-1:0] out_status_ff, out_status_in;
   logic [WW-1:0] out_word_ff, out_word_in;
   logic          out_last_ff, out_last_in;

   logic          req_fire, rsp_fire;
   logic          word_ok, hdr_hit, crc_more;
   logic [DW-1:0] count_x, hpos_x, span;
   logic [TW-1:0] pre_status;
   logic          pre_pass, crc_match;
   logic [6:0]    rd_off;
   logic [SW-1:0] rd_sum;
   logic [AW-1:0] rd_addr;
   logic [WW-1:0] rd_data;
   logic          wr_en;
   logic          crc_busy;
   logic [WW-1:0] crc_val;
   spifrc_pkg::crc_ctrl_type crc_ctrl;

   spifrc_ram #(
      .WIDTH(WW),
      .DEPTH(BUFFER_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spifrc_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .word  (req_tdata),
      .crc   (crc_val),
      .busy  (crc_busy)
   );

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   assign count_x = DW'(count_ff);
   assign hpos_x  = DW'(hpos_ff);
   assign span    = count_x - hpos_x;

   assign word_ok  = req_fire && (req_tuser == spifrc_pkg::CMD_WORD) && (count_x < BUF_LEN);
   assign hdr_hit  = !seen_ff && (req_tdata == hdr_ff);
   assign crc_more = seen_ff && (span < CRC_SPAN);

   // checks at release; rd_data holds the word after the header here
   always_comb begin
      pre_pass = 1'b0;
      if (!seen_ff) begin
         pre_status = spifrc_pkg::STATUS_NO_HEADER;
      end else if (hpos_x + DW'(1) >= count_x) begin
         pre_status = spifrc_pkg::STATUS_INCOMPLETE;
      end else if (rd_data != ver_ff) begin
         pre_status = spifrc_pkg::STATUS_BAD_VERSION;
      end else if (span < FRAME_LEN) begin
         pre_status = spifrc_pkg::STATUS_INCOMPLETE;
      end else begin
         pre_status = spifrc_pkg::STATUS_OK;
         pre_pass   = 1'b1;
      end
   end

   assign crc_match = (rd_data == crc_val);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spifrc_pkg::ST_IDLE: begin
            if (req_fire && (req_tuser == spifrc_pkg::CMD_RELEASE)) begin
               state_in = spifrc_pkg::ST_VER;
            end
         end
         spifrc_pkg::ST_VER:  state_in = pre_pass ? spifrc_pkg::ST_CRC : spifrc_pkg::ST_SEND;
         spifrc_pkg::ST_CRC:  state_in = crc_match ? spifrc_pkg::ST_LOAD : spifrc_pkg::ST_SEND;
         spifrc_pkg::ST_LOAD: state_in = spifrc_pkg::ST_SEND;
         spifrc_pkg::ST_SEND: begin
            if (rsp_tready) begin
               state_in = out_last_ff ? spifrc_pkg::ST_IDLE : spifrc_pkg::ST_LOAD;
            end
         end
         default: state_in = spifrc_pkg::ST_IDLE;
      endcase
   end

   // state-driven controls
   always_comb begin
      rd_off     = OFF_VER;
      wr_en      = 1'b0;
      crc_ctrl   = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         spifrc_pkg::ST_IDLE: begin
            req_tready       = !crc_busy;
            wr_en            = word_ok;
            crc_ctrl.start   = word_ok && (hdr_hit || crc_more);
            crc_ctrl.restart = word_ok && hdr_hit;
         end
         spifrc_pkg::ST_VER:  rd_off = OFF_CRC;
         spifrc_pkg::ST_CRC:  rd_off = OFF_CMD;
         spifrc_pkg::ST_LOAD: rd_off = OFF_CMD + 7'(idx_ff);
         spifrc_pkg::ST_SEND: begin
            rsp_tvalid     = 1'b1;
            rd_off         = OFF_CMD + 7'(idx_ff) + 7'd1;
            crc_ctrl.clear = rsp_tready && out_last_ff;
         end
         default: ;
      endcase
   end

   assign rd_sum  = SW'(hpos_ff) + SW'(rd_off);
   assign rd_addr = rd_sum[AW-1:0];

   // datapath next values
   always_comb begin
      hdr_in        = hdr_ff;
      ver_in        = ver_ff;
      count_in      = count_ff;
      seen_in       = seen_ff;
      hpos_in       = hpos_ff;
      serr_in       = serr_ff;
      cerr_in       = cerr_ff;
      idx_in        = idx_ff;
      out_status_in = out_status_ff;
      out_word_in   = out_word_ff;
      out_last_in   = out_last_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            spifrc_pkg::REG_HEADER:  hdr_in = csr_wr_data;
            spifrc_pkg::REG_VERSION: ver_in = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         spifrc_pkg::ST_IDLE: begin
            if (word_ok) begin
               count_in = count_ff + CW'(1);
               if (hdr_hit) begin
                  seen_in = 1'b1;
                  hpos_in = count_ff[AW-1:0];
               end
            end
         end
         spifrc_pkg::ST_VER: begin
            idx_in        = '0;
            out_status_in = pre_status;
            out_word_in   = '0;
            out_last_in   = 1'b1;
            if (!pre_pass && (pre_status != spifrc_pkg::STATUS_NO_HEADER)) begin
               serr_in = serr_ff + WW'(1);
            end
         end
         spifrc_pkg::ST_CRC: begin
            idx_in = '0;
            if (!crc_match) begin
               out_status_in = spifrc_pkg::STATUS_BAD_CRC;
               out_word_in   = '0;
               out_last_in   = 1'b1;
               cerr_in       = cerr_ff + WW'(1);
            end
         end
         spifrc_pkg::ST_LOAD: begin
            out_status_in = spifrc_pkg::STATUS_OK;
            out_word_in   = rd_data;
            out_last_in   = (idx_ff == LAST_IDX);
         end
         spifrc_pkg::ST_SEND: begin
            if (rsp_fire) begin
               if (out_last_ff) begin
                  count_in = '0;
                  seen_in  = 1'b0;
                  hpos_in  = '0;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= spifrc_pkg::ST_IDLE;
         hdr_ff      <= spifrc_pkg::HEADER_RESET;
         ver_ff      <= spifrc_pkg::VERSION_RESET;
         count_ff    <= '0;
         seen_ff     <= 1'b0;
         hpos_ff     <= '0;
         serr_ff     <= '0;
         cerr_ff     <= '0;
         idx_ff      <= '0;
         out_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         hdr_ff      <= hdr_in;
         ver_ff      <= ver_in;
         count_ff    <= count_in;
         seen_ff     <= seen_in;
         hpos_ff     <= hpos_in;
         serr_ff     <= serr_in;
         cerr_ff     <= cerr_in;
         idx_ff      <= idx_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_word_ff   <= out_word_in;
   end

   assign rsp_tdata = {2'b00, cerr_ff, serr_ff, idx_ff, out_word_ff};
   assign rsp_tuser = out_status_ff;
   assign rsp_tlast = out_last_ff;

endmodule

// ----- tb/tb.sv -----
// Testbench for spi_frame_receiver_crc_check: frame search, version, length and CRC checks.
// Depends on spifrc_pkg and the RTL of the block. It has its own frame model and a result checker.
`timescale 1ns / 1ps

module tb;

   localparam int WORD_W       = spifrc_pkg::WORD_W;
   localparam int STATUS_W     = spifrc_pkg::STATUS_W;
   localparam int INDEX_W      = spifrc_pkg::INDEX_W;
   localparam int BUFFER_WORDS = 32;
   localparam int FRAME_WORDS  = 16;
   localparam int DRAIN_GAP    = 8;     // margin after the last result transaction
   localparam int WATCHDOG_MAX = 2000;
   localparam int ITEM_GOAL    = 380;
   localparam int HOLD_CYCLES  = 200;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   cmd_word;
      logic [INDEX_W-1:0]  word_index;
      logic                last;
      logic [WORD_W-1:0]   struct_errors;
      logic [WORD_W-1:0]   crc_errors;
   } frame_result_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // rx_word[15:0]
   logic        req_tuser;    // command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;    // cmd_word[15:0], word_index[21:16],
                              // struct_errors[37:22], crc_errors[53:38]
   logic [2:0]  rsp_tuser;    // status
   logic        rsp_tlast;    // last

   // frame model state
   logic [WORD_W-1:0] exp_header;
   logic [WORD_W-1:0] exp_version;
   logic [WORD_W-1:0] word_mem [BUFFER_WORDS];
   int                rx_count;
   logic              hdr_seen;
   int                hdr_pos;
   logic [WORD_W-1:0] frame_crc;
   logic [WORD_W-1:0] struct_err_cnt;
   logic [WORD_W-1:0] crc_err_cnt;

   frame_result_type  expected_results [$];
   logic [WORD_W-1:0] xfer_words [$];
   int                items_sent;
   int                mismatches = 0;
   int                idle_pct;
   int                stall_pct;
   int                hold_reqs;
   int                hold_done = 0;
   int                hold_left = 0;
   int                quiet_cycles = 0;

   spi_frame_receiver_crc_check #(
      .BUFFER_WORDS(BUFFER_WORDS),
      .FRAME_WORDS (FRAME_WORDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [WORD_W-1:0] crc16_update(input logic [WORD_W-1:0] crc,
                                                     input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] c;
      c = crc ^ w;
      for (int b = 0; b < WORD_W; b++) begin
         if (c[WORD_W-1]) c = (c << 1) ^ spifrc_pkg::CRC_POLY;
         else c = c << 1;
      end
      return c;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_result(input logic [STATUS_W-1:0] st, input logic [WORD_W-1:0] w,
                              input int idx, input logic last);
      frame_result_type r;
      r.status        = st;
      r.cmd_word      = w;
      r.word_index    = INDEX_W'(idx);
      r.last          = last;
      r.struct_errors = struct_err_cnt;
      r.crc_errors    = crc_err_cnt;
      expected_results.push_back(r);
   endtask

   // Updates the frame model with one accepted transaction and, for a release, queues its results.
   task automatic frame_model_step(input logic cmd, input logic [WORD_W-1:0] w);
      logic [STATUS_W-1:0] st;
      if (cmd == spifrc_pkg::CMD_WORD) begin
         if (rx_count < BUFFER_WORDS) begin
            word_mem[rx_count] = w;
            if (!hdr_seen) begin
               if (w == exp_header) begin
                  hdr_seen  = 1'b1;
                  hdr_pos   = rx_count;
                  frame_crc = crc16_update(spifrc_pkg::CRC_SEED, w);
               end
            end else if (rx_count - hdr_pos < FRAME_WORDS - 1) begin
               frame_crc = crc16_update(frame_crc, w);
            end
            rx_count++;
         end
         return;
      end
      if (!hdr_seen) st = spifrc_pkg::STATUS_NO_HEADER;
      else if (hdr_pos + 1 >= rx_count) st = spifrc_pkg::STATUS_INCOMPLETE;
      else if (word_mem[hdr_pos + 1] != exp_version) st = spifrc_pkg::STATUS_BAD_VERSION;
      else if (rx_count - hdr_pos < FRAME_WORDS) st = spifrc_pkg::STATUS_INCOMPLETE;
      else if (frame_crc != word_mem[hdr_pos + FRAME_WORDS - 1])
         st = spifrc_pkg::STATUS_BAD_CRC;
      else st = spifrc_pkg::STATUS_OK;
      if (st == spifrc_pkg::STATUS_BAD_VERSION || st == spifrc_pkg::STATUS_INCOMPLETE)
         struct_err_cnt++;
      else if (st == spifrc_pkg::STATUS_BAD_CRC) crc_err_cnt++;
      if (st != spifrc_pkg::STATUS_OK) begin
         push_result(st, '0, 0, 1'b1);
      end else begin
         // the whole frame lies inside the store whenever it passes the length check
         for (int i = 0; i < FRAME_WORDS - 2; i++)
            push_result(spifrc_pkg::STATUS_OK, word_mem[hdr_pos + 2 + i], i,
                        i == FRAME_WORDS - 3);
      end
      rx_count  = 0;
      hdr_seen  = 1'b0;
      hdr_pos   = 0;
      frame_crc = spifrc_pkg::CRC_SEED;
   endtask

   task automatic send_item(input logic cmd, input logic [WORD_W-1:0] w);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      frame_model_step(cmd, w);
      items_sent++;
   endtask

   task automatic send_transfer();
      foreach (xfer_words[i]) send_item(spifrc_pkg::CMD_WORD, xfer_words[i]);
      send_item(spifrc_pkg::CMD_RELEASE, 16'($urandom));
      xfer_words.delete();
   endtask

   task automatic queue_noise(input int n);
      repeat (n) xfer_words.push_back(16'($urandom));
   endtask

   // Queues the first len words of a frame: header, version, payload, CRC.
   task automatic queue_frame(input logic [WORD_W-1:0] hdr, input logic [WORD_W-1:0] ver,
                              input int len, input bit bad_crc);
      logic [WORD_W-1:0] fw [FRAME_WORDS];
      logic [WORD_W-1:0] crc;
      fw[0] = hdr;
      fw[1] = ver;
      for (int i = 2; i < FRAME_WORDS - 1; i++) fw[i] = rand_word();
      crc = spifrc_pkg::CRC_SEED;
      for (int i = 0; i < FRAME_WORDS - 1; i++) crc = crc16_update(crc, fw[i]);
      fw[FRAME_WORDS-1] = bad_crc ? crc ^ (16'h1 << $urandom_range(15)) : crc;
      for (int i = 0; i < len; i++) xfer_words.push_back(fw[i]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [WORD_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      if (idx == spifrc_pkg::REG_HEADER) exp_header = value;
      else exp_version = value;
   endtask

   task automatic set_registers(input logic [WORD_W-1:0] hdr, input logic [WORD_W-1:0] ver);
      csr_write(spifrc_pkg::REG_HEADER, hdr);
      csr_write(spifrc_pkg::REG_VERSION, ver);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_transfer();
      int pick;
      pick = $urandom_range(99);
      queue_noise(($urandom_range(4) == 0) ? $urandom_range(20) : $urandom_range(3));
      if (pick < 55) queue_frame(exp_header, exp_version, FRAME_WORDS, 0);
      else if (pick < 65) queue_frame(exp_header, exp_version, FRAME_WORDS, 1);
      else if (pick < 75)
         queue_frame(exp_header, exp_version ^ 16'($urandom_range(1, 16'hFFFF)), FRAME_WORDS, 0);
      else if (pick < 85)
         queue_frame(exp_header, exp_version, $urandom_range(1, FRAME_WORDS - 1), 0);
      else if (pick < 93) queue_noise($urandom_range(40));
      else xfer_words.delete();
      if (pick < 93 && $urandom_range(4) == 0) queue_noise($urandom_range(20));
      send_transfer();
   endtask

   // One transfer per status code, with the register defaults.
   task automatic test_status_codes();
      send_transfer();
      queue_frame(exp_header, exp_version, 1, 0);
      send_transfer();
      queue_frame(exp_header, ~exp_version, 2, 0);
      send_transfer();
      queue_frame(exp_header, exp_version, FRAME_WORDS, 0);
      send_transfer();
      queue_frame(exp_header, exp_version, FRAME_WORDS, 1);
      send_transfer();
      wait_drained();
   endtask

   task automatic test_registers();
      logic [WORD_W-1:0] hdr_vals [3];
      logic [WORD_W-1:0] ver_vals [3];
      hdr_vals = '{16'h0000, 16'hFFFF, 16'($urandom)};
      ver_vals = '{16'hFFFF, 16'h0000, 16'($urandom)};
      for (int s = 0; s < 3; s++) begin
         set_registers(hdr_vals[s], ver_vals[s]);
         queue_frame(exp_header, exp_version, FRAME_WORDS, 0);
         send_transfer();
         queue_noise(2);
         queue_frame(exp_header, ~exp_version, FRAME_WORDS, 0);
         send_transfer();
         wait_drained();
      end
      set_registers(spifrc_pkg::HEADER_RESET, spifrc_pkg::VERSION_RESET);
   endtask

   // Receiver holds off while good frames keep coming, then the sender waits it out.
   task automatic test_backpressure();
      hold_reqs++;
      repeat (3) begin
         queue_frame(exp_header, exp_version, FRAME_WORDS, 0);
         send_transfer();
      end
      wait_drained();
   endtask

   task automatic test_no_idle_stretch();
      idle_pct  = 0;
      stall_pct = 0;
      repeat (5) random_transfer();
      wait_drained();
      idle_pct  = 13;
      stall_pct = 13;
   endtask

   task automatic test_random_frames();
      int n_xfer;
      n_xfer = 0;
      while (items_sent < ITEM_GOAL) begin
         if (n_xfer % 10 == 9) begin
            wait_drained();
            if ($urandom_range(1))
               set_registers(spifrc_pkg::HEADER_RESET, spifrc_pkg::VERSION_RESET);
            else set_registers(16'($urandom), 16'($urandom));
         end
         random_transfer();
         n_xfer++;
      end
      wait_drained();
   endtask

   always @(posedge clock) begin : rsp_ready_drive
      if (hold_reqs != hold_done) begin
         hold_done = hold_reqs;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [WORD_W-1:0] want_v,
                              input logic [WORD_W-1:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with none expected, status %0d", rsp_tuser);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", WORD_W'(want.status), WORD_W'(rsp_tuser));
            check_field("cmd_word", want.cmd_word, rsp_tdata[15:0]);
            check_field("word_index", WORD_W'(want.word_index), WORD_W'(rsp_tdata[21:16]));
            check_field("last", WORD_W'(want.last), WORD_W'(rsp_tlast));
            check_field("struct_errors", want.struct_errors, rsp_tdata[37:22]);
            check_field("crc_errors", want.crc_errors, rsp_tdata[53:38]);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= spifrc_pkg::REG_HEADER;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= spifrc_pkg::CMD_WORD;
      exp_header     = spifrc_pkg::HEADER_RESET;
      exp_version    = spifrc_pkg::VERSION_RESET;
      rx_count       = 0;
      hdr_seen       = 1'b0;
      hdr_pos        = 0;
      frame_crc      = spifrc_pkg::CRC_SEED;
      struct_err_cnt = '0;
      crc_err_cnt    = '0;
      items_sent     = 0;
      idle_pct       = 13;
      stall_pct      = 13;
      hold_reqs      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_status_codes();
      test_registers();
      test_backpressure();
      test_no_idle_stretch();
      test_random_frames();

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
